@@ rtl/phc_pkg.sv @@
// shared types and constants of the periodic timer heap
`default_nettype none

package phc_pkg;

    // field widths fixed by the interface
    localparam int DUE_W   = 48;
    localparam int IVL_W   = 32;
    localparam int TAG_W   = 8;
    localparam int ORDER_W = 16;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 5;

    // insertion rank at which the held timers get renumbered
    localparam logic [ORDER_W-1:0] ORDER_WRAP = 16'hFFFF;

    // largest due time, the saturation value of a reload
    localparam logic [DUE_W-1:0] DUE_MAX = 48'hFFFF_FFFF_FFFF;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE_DUE = 2'd3;

    // request codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // one stored timer
    typedef struct packed {
        logic [DUE_W-1:0]   due;
        logic [IVL_W-1:0]   ivl;
        logic [TAG_W-1:0]   tag;
        logic [ORDER_W-1:0] order;
        logic               epoch;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/phc_store.sv @@
// timer slot memory with one write port and one registered read port
`default_nettype none

module phc_store #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire phc_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output phc_pkg::entry_t      rdata
);

    phc_pkg::entry_t mem [CAPACITY];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/phc_ctrl.sv @@
// sequencer: scans, removes, reinserts and renumbers timers in the slot memory
`default_nettype none

module phc_ctrl #(
    parameter int CAPACITY           = 16,
    parameter int MAX_FIRES_PER_TICK = 16,
    parameter int AW                 = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            func,
    input  wire logic [phc_pkg::DUE_W-1:0]       due_time,
    input  wire logic [phc_pkg::IVL_W-1:0]       reload_interval,
    input  wire logic [phc_pkg::TAG_W-1:0]       timer_tag,
    input  wire logic [phc_pkg::DUE_W-1:0]       current_time,
    output logic                                 busy,
    output logic                                 result_valid,
    output logic [phc_pkg::KIND_W-1:0]           kind,
    output logic [phc_pkg::TAG_W-1:0]            fired_tag,
    output logic [phc_pkg::DUE_W-1:0]            fired_due_time,
    output logic [phc_pkg::CNT_W-1:0]            pending_count,
    output logic                                 last,
    output logic                                 mem_we,
    output logic [AW-1:0]                        mem_waddr,
    output phc_pkg::entry_t                      mem_wdata,
    output logic                                 mem_re,
    output logic [AW-1:0]                        mem_raddr,
    input  wire phc_pkg::entry_t                 mem_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = $clog2(MAX_FIRES_PER_TICK + 1);
    localparam logic [CW-1:0] CAP_N = CW'(CAPACITY);
    localparam logic [NW-1:0] MAX_N = NW'(MAX_FIRES_PER_TICK);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_PICK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_REINS,
        S_FIRED,
        S_RN_START,
        S_RN_CHK,
        S_RN_WR
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]             held_reg, held_next;
    logic [phc_pkg::ORDER_W-1:0] ctr_reg, ctr_next;
    logic                      epoch_reg, epoch_next;
    logic [NW-1:0]             n_reg, n_next;
    logic                      tick_mode_reg, tick_mode_next;
    logic [CW-1:0]             issue_reg, issue_next;
    logic                      rdv_reg, rdv_next;
    logic [AW-1:0]             rdidx_reg, rdidx_next;
    logic                      have_reg, have_next;
    phc_pkg::entry_t           best_reg, best_next;
    logic [AW-1:0]             bidx_reg, bidx_next;
    logic [CW-1:0]             rnk_reg, rnk_next;
    logic                      ret_reins_reg, ret_reins_next;
    logic [phc_pkg::DUE_W-1:0] due_reg, due_next;
    logic [phc_pkg::IVL_W-1:0] ivl_reg, ivl_next;
    logic [phc_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [phc_pkg::DUE_W-1:0] now_reg, now_next;
    logic [phc_pkg::DUE_W-1:0] fdue_reg, fdue_next;
    logic [phc_pkg::IVL_W-1:0] fivl_reg, fivl_next;
    logic [phc_pkg::TAG_W-1:0] ftag_reg, ftag_next;
    logic [phc_pkg::TAG_W-1:0] ptag_reg, ptag_next;
    logic [phc_pkg::DUE_W-1:0] pdue_reg, pdue_next;
    logic [CW-1:0]             pcnt_reg, pcnt_next;
    logic                      ov_reg, ov_next;
    logic [phc_pkg::KIND_W-1:0] okind_reg, okind_next;
    logic [phc_pkg::TAG_W-1:0] otag_reg, otag_next;
    logic [phc_pkg::DUE_W-1:0] odue_reg, odue_next;
    logic [CW-1:0]             ocnt_reg, ocnt_next;
    logic                      olast_reg, olast_next;

    logic                      cand_elig;
    logic                      cand_better;
    logic [phc_pkg::DUE_W:0]   reload_sum;
    logic [phc_pkg::DUE_W-1:0] reload_due;
    logic [CW-1:0]             held_m1;

    // candidate compare for the running minimum of a scan
    always_comb
    begin
        cand_elig = tick_mode_reg || (mem_rdata.epoch != epoch_reg);
        if (!have_reg)
        begin
            cand_better = 1'b1;
        end
        else if (tick_mode_reg)
        begin
            cand_better = (mem_rdata.due < best_reg.due) ||
                          ((mem_rdata.due == best_reg.due) &&
                           (mem_rdata.order < best_reg.order));
        end
        else
        begin
            cand_better = mem_rdata.order < best_reg.order;
        end
    end

    // saturating reload of a fired timer
    assign reload_sum = {1'b0, fdue_reg} + {{(phc_pkg::DUE_W + 1 - phc_pkg::IVL_W){1'b0}},
                                              fivl_reg};
    assign reload_due = reload_sum[phc_pkg::DUE_W] ? phc_pkg::DUE_MAX
                                                    : reload_sum[phc_pkg::DUE_W-1:0];
    assign held_m1    = held_reg - 1'b1;

    // next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        ctr_next       = ctr_reg;
        epoch_next     = epoch_reg;
        n_next         = n_reg;
        tick_mode_next = tick_mode_reg;
        issue_next     = issue_reg;
        rdv_next       = 1'b0;
        rdidx_next     = rdidx_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        bidx_next      = bidx_reg;
        rnk_next       = rnk_reg;
        ret_reins_next = ret_reins_reg;
        due_next       = due_reg;
        ivl_next       = ivl_reg;
        tag_next       = tag_reg;
        now_next       = now_reg;
        fdue_next      = fdue_reg;
        fivl_next      = fivl_reg;
        ftag_next      = ftag_reg;
        ptag_next      = ptag_reg;
        pdue_next      = pdue_reg;
        pcnt_next      = pcnt_reg;
        ov_next        = 1'b0;
        okind_next     = okind_reg;
        otag_next      = otag_reg;
        odue_next      = odue_reg;
        ocnt_next      = ocnt_reg;
        olast_next     = olast_reg;
        mem_we         = 1'b0;
        mem_waddr      = held_reg[AW-1:0];
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = issue_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    due_next      = due_time;
                    ivl_next      = reload_interval;
                    tag_next      = timer_tag;
                    now_next      = current_time;
                    n_next        = '0;
                    issue_next    = '0;
                    have_next     = 1'b0;
                    tick_mode_next = 1'b1;
                    if (func == phc_pkg::FUNC_ADD)
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // add transaction: reject, renumber first, or write the new slot
            S_ADD:
            begin
                if (held_reg == CAP_N)
                begin
                    ov_next    = 1'b1;
                    okind_next = phc_pkg::KIND_REJECTED;
                    otag_next  = '0;
                    odue_next  = '0;
                    ocnt_next  = held_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (ctr_reg == phc_pkg::ORDER_WRAP)
                begin
                    ret_reins_next = 1'b0;
                    state_next     = S_RN_START;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = held_reg[AW-1:0];
                    mem_wdata.due   = due_reg;
                    mem_wdata.ivl   = ivl_reg;
                    mem_wdata.tag   = tag_reg;
                    mem_wdata.order = ctr_reg;
                    mem_wdata.epoch = epoch_reg;
                    ctr_next        = ctr_reg + 1'b1;
                    held_next       = held_reg + 1'b1;
                    ov_next         = 1'b1;
                    okind_next      = phc_pkg::KIND_ADDED;
                    otag_next       = '0;
                    odue_next       = '0;
                    ocnt_next       = held_reg + 1'b1;
                    olast_next      = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // streaming scan over the held slots, one read per cycle
            S_SCAN:
            begin
                if (rdv_reg && cand_elig && cand_better)
                begin
                    have_next = 1'b1;
                    best_next = mem_rdata;
                    bidx_next = rdidx_reg;
                end
                if (issue_reg < held_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = issue_reg[AW-1:0];
                    rdv_next   = 1'b1;
                    rdidx_next = issue_reg[AW-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                else if (!rdv_reg)
                begin
                    state_next = tick_mode_reg ? S_PICK : S_RN_WR;
                end
            end

            // decide whether the earliest timer fires
            S_PICK:
            begin
                if (have_reg && (best_reg.due <= now_reg))
                begin
                    if (n_reg != '0)
                    begin
                        ov_next    = 1'b1;
                        okind_next = phc_pkg::KIND_FIRED;
                        otag_next  = ptag_reg;
                        odue_next  = pdue_reg;
                        ocnt_next  = pcnt_reg;
                        olast_next = 1'b0;
                    end
                    fdue_next = best_reg.due;
                    fivl_next = best_reg.ivl;
                    ftag_next = best_reg.tag;
                    held_next = held_m1;
                    if (bidx_reg != held_m1[AW-1:0])
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else if (best_reg.ivl != '0)
                    begin
                        state_next = S_REINS;
                    end
                    else
                    begin
                        state_next = S_FIRED;
                    end
                end
                else
                begin
                    ov_next    = 1'b1;
                    olast_next = 1'b1;
                    if (n_reg == '0)
                    begin
                        okind_next = phc_pkg::KIND_NONE_DUE;
                        otag_next  = '0;
                        odue_next  = '0;
                        ocnt_next  = held_reg;
                    end
                    else
                    begin
                        okind_next = phc_pkg::KIND_FIRED;
                        otag_next  = ptag_reg;
                        odue_next  = pdue_reg;
                        ocnt_next  = pcnt_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            // fill the freed slot with the final entry
            S_MOVE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = held_reg[AW-1:0];
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = bidx_reg;
                mem_wdata  = mem_rdata;
                state_next = (fivl_reg != '0) ? S_REINS : S_FIRED;
            end

            // reinsert a periodic timer with a fresh rank
            S_REINS:
            begin
                if (ctr_reg == phc_pkg::ORDER_WRAP)
                begin
                    ret_reins_next = 1'b1;
                    state_next     = S_RN_START;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = held_reg[AW-1:0];
                    mem_wdata.due   = reload_due;
                    mem_wdata.ivl   = fivl_reg;
                    mem_wdata.tag   = ftag_reg;
                    mem_wdata.order = ctr_reg;
                    mem_wdata.epoch = epoch_reg;
                    ctr_next        = ctr_reg + 1'b1;
                    held_next       = held_reg + 1'b1;
                    state_next      = S_FIRED;
                end
            end

            // hold the fired result until the next decision marks it last or not, or emit it as last at the fire limit
            S_FIRED:
            begin
                n_next    = n_reg + 1'b1;
                ptag_next = ftag_reg;
                pdue_next = fdue_reg;
                pcnt_next = held_reg;
                if ((n_reg + 1'b1) == MAX_N)
                begin
                    ov_next    = 1'b1;
                    okind_next = phc_pkg::KIND_FIRED;
                    otag_next  = ftag_reg;
                    odue_next  = fdue_reg;
                    ocnt_next  = held_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    tick_mode_next = 1'b1;
                    issue_next     = '0;
                    have_next      = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            // renumber: flip the epoch, then rank entries one minimum at a time
            S_RN_START:
            begin
                epoch_next = ~epoch_reg;
                rnk_next   = '0;
                state_next = S_RN_CHK;
            end

            S_RN_CHK:
            begin
                if (rnk_reg == held_reg)
                begin
                    ctr_next   = phc_pkg::ORDER_W'(held_reg);
                    state_next = ret_reins_reg ? S_REINS : S_ADD;
                end
                else
                begin
                    tick_mode_next = 1'b0;
                    issue_next     = '0;
                    have_next      = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_RN_WR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = bidx_reg;
                mem_wdata       = best_reg;
                mem_wdata.order = phc_pkg::ORDER_W'(rnk_reg);
                mem_wdata.epoch = epoch_reg;
                rnk_next        = rnk_reg + 1'b1;
                state_next      = S_RN_CHK;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            ctr_reg       <= '0;
            epoch_reg     <= 1'b0;
            n_reg         <= '0;
            tick_mode_reg <= 1'b1;
            issue_reg     <= '0;
            rdv_reg       <= 1'b0;
            have_reg      <= 1'b0;
            rnk_reg       <= '0;
            ret_reins_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            ctr_reg       <= ctr_next;
            epoch_reg     <= epoch_next;
            n_reg         <= n_next;
            tick_mode_reg <= tick_mode_next;
            issue_reg     <= issue_next;
            rdv_reg       <= rdv_next;
            have_reg      <= have_next;
            rnk_reg       <= rnk_next;
            ret_reins_reg <= ret_reins_next;
            ov_reg        <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rdidx_reg <= rdidx_next;
        best_reg  <= best_next;
        bidx_reg  <= bidx_next;
        due_reg   <= due_next;
        ivl_reg   <= ivl_next;
        tag_reg   <= tag_next;
        now_reg   <= now_next;
        fdue_reg  <= fdue_next;
        fivl_reg  <= fivl_next;
        ftag_reg  <= ftag_next;
        ptag_reg  <= ptag_next;
        pdue_reg  <= pdue_next;
        pcnt_reg  <= pcnt_next;
        okind_reg <= okind_next;
        otag_reg  <= otag_next;
        odue_reg  <= odue_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    // result ports
    assign busy           = state_reg != S_IDLE;
    assign result_valid   = ov_reg;
    assign kind           = okind_reg;
    assign fired_tag      = otag_reg;
    assign fired_due_time = odue_reg;
    assign pending_count  = phc_pkg::CNT_W'(ocnt_reg);
    assign last           = olast_reg;

endmodule

`default_nettype wire

@@ rtl/periodic_timer_heap.sv @@
// periodic timer heap: top level joining the sequencer and the slot memory
// an add transaction renumbers the held ranks first when the rank counter has wrapped
// a tick scans the N held slots once per fired timer, since the slot memory has a single
// read port; one transaction in flight at a time
// results are single-cycle strobes that the receiver cannot stall
// reset clears the held count and rank counter; slot contents stay undefined
`default_nettype none

module periodic_timer_heap #(
    parameter int CAPACITY           = 16,
    parameter int MAX_FIRES_PER_TICK = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      func,
    input  wire logic [phc_pkg::DUE_W-1:0] due_time,
    input  wire logic [phc_pkg::IVL_W-1:0] reload_interval,
    input  wire logic [phc_pkg::TAG_W-1:0] timer_tag,
    input  wire logic [phc_pkg::DUE_W-1:0] current_time,
    output logic                           busy,
    output logic                           result_valid,
    output logic [phc_pkg::KIND_W-1:0]     kind,
    output logic [phc_pkg::TAG_W-1:0]      fired_tag,
    output logic [phc_pkg::DUE_W-1:0]      fired_due_time,
    output logic [phc_pkg::CNT_W-1:0]      pending_count,
    output logic                           last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    phc_pkg::entry_t mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    phc_pkg::entry_t mem_rdata;

    // sequencer
    phc_ctrl #(
        .CAPACITY           (CAPACITY),
        .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK),
        .AW                 (AW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .func            (func),
        .due_time        (due_time),
        .reload_interval (reload_interval),
        .timer_tag       (timer_tag),
        .current_time    (current_time),
        .busy            (busy),
        .result_valid    (result_valid),
        .kind            (kind),
        .fired_tag       (fired_tag),
        .fired_due_time  (fired_due_time),
        .pending_count   (pending_count),
        .last            (last),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    // slot memory
    phc_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/phc_checker.sv @@
// port-level checks of the periodic timer heap, bound to the top level
`default_nettype none

module phc_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      result_valid,
    input wire logic [phc_pkg::KIND_W-1:0] kind,
    input wire logic [phc_pkg::TAG_W-1:0] fired_tag,
    input wire logic [phc_pkg::DUE_W-1:0] fired_due_time,
    input wire logic [phc_pkg::CNT_W-1:0] pending_count,
    input wire logic                      last
);

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // the final result of a transaction frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("busy still high with final result");

    // add and empty-tick results are single
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind != phc_pkg::KIND_FIRED) |-> last)
        else $error("non-fire result without last");

    // only fired results carry a tag and due time
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind != phc_pkg::KIND_FIRED) |->
            (fired_tag == '0 && fired_due_time == '0))
        else $error("non-fire result carries payload");

    // pending count never exceeds the capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(pending_count) <= CAPACITY))
        else $error("pending count above capacity");

endmodule

bind periodic_timer_heap phc_checker #(
    .CAPACITY (CAPACITY)
) u_phc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .result_valid   (result_valid),
    .kind           (kind),
    .fired_tag      (fired_tag),
    .fired_due_time (fired_due_time),
    .pending_count  (pending_count),
    .last           (last)
);

`default_nettype wire
